FILE: rtl/core/plca_pkg.sv
`default_nettype none
package plca_pkg;

    // coordinate and arithmetic widths
    localparam int X_BITS      = 7;
    localparam int Y_BITS      = 6;
    localparam int DX_W        = X_BITS + 1;
    localparam int DY_W        = Y_BITS + 1;
    localparam int D2_W        = 16;
    localparam int PROD_W      = 17;
    localparam int CORDIC_W    = 40;
    localparam int Z_W         = 27;
    localparam int ATAN_W      = 22;
    localparam int PRESCALE_SH = 20;
    localparam int ANG_FRAC    = 16;
    localparam int SQRT_STEPS  = 8;
    localparam int IDX_W       = 5;

    // angle constants, degrees with 16 fraction bits
    localparam logic signed [Z_W-1:0] ANG_180  = Z_W'(180 * 65536);
    localparam logic signed [Z_W-1:0] ANG_360  = Z_W'(360 * 65536);
    localparam logic signed [Z_W-1:0] ANG_HALF = Z_W'(32768);

    // commands
    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_ERASE   = 2'd1;
    localparam logic [1:0] CMD_RESTORE = 2'd2;

    // shape kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_POINT  = 2'd1;
    localparam logic [1:0] KIND_OPEN   = 2'd2;
    localparam logic [1:0] KIND_CLOSED = 2'd3;

    // configuration register indexes
    localparam logic CFG_TOL  = 1'b0;
    localparam logic CFG_MAXP = 1'b1;

    // reset values of configuration
    localparam logic [13:0] TOL_RESET  = 14'd25;
    localparam logic [7:0]  MAXP_RESET = 8'd101;

    // controller to datapath commands
    typedef struct packed {
        logic             load;
        logic             diff1;
        logic             close;
        logic             diff2;
        logic             mul;
        logic             init;
        logic             step;
        logic             finish;
        logic [IDX_W-1:0] idx;
    } t_ctl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_ctl_stat;

    // rounded atan(2^-i) in degrees, 16 fraction bits
    function automatic logic [ATAN_W-1:0] atan_deg(input logic [IDX_W-1:0] i);
        logic [ATAN_W-1:0] a;
        case (i)
            5'd0:  a = 22'd2949120;
            5'd1:  a = 22'd1740967;
            5'd2:  a = 22'd919879;
            5'd3:  a = 22'd466945;
            5'd4:  a = 22'd234379;
            5'd5:  a = 22'd117304;
            5'd6:  a = 22'd58666;
            5'd7:  a = 22'd29335;
            5'd8:  a = 22'd14668;
            5'd9:  a = 22'd7334;
            5'd10: a = 22'd3667;
            5'd11: a = 22'd1833;
            5'd12: a = 22'd917;
            5'd13: a = 22'd458;
            5'd14: a = 22'd229;
            5'd15: a = 22'd115;
            5'd16: a = 22'd57;
            5'd17: a = 22'd29;
            5'd18: a = 22'd14;
            5'd19: a = 22'd7;
            5'd20: a = 22'd4;
            5'd21: a = 22'd2;
            5'd22: a = 22'd1;
            default: a = 22'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/plca_ctrl.sv
`default_nettype none
module plca_ctrl #(
    parameter int ANGLE_ITERS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  plca_pkg::t_ctl_stat i_stat,
    output plca_pkg::t_ctl_cmd  o_cmd
);
    import plca_pkg::*;

    localparam int ITER_N = (ANGLE_ITERS > SQRT_STEPS) ? ANGLE_ITERS : SQRT_STEPS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIFF1 = 3'd1;
    localparam logic [2:0] S_CLOSE = 3'd2;
    localparam logic [2:0] S_DIFF2 = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_INIT  = 3'd5;
    localparam logic [2:0] S_ITER  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_iter, n_iter;
    logic             accept;

    assign accept     = i_s_tvalid && (r_state == S_IDLE);
    assign o_s_tready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        o_cmd   = '0;
        o_cmd.idx = r_iter;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIFF1;
                end
            end
            S_DIFF1: begin
                o_cmd.diff1 = 1'b1;
                n_state     = S_CLOSE;
            end
            S_CLOSE: begin
                o_cmd.close = 1'b1;
                n_state     = S_DIFF2;
            end
            S_DIFF2: begin
                o_cmd.diff2 = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_INIT;
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_iter     = '0;
                n_state    = S_ITER;
            end
            S_ITER: begin
                o_cmd.step = 1'b1;
                n_iter     = r_iter + 1'b1;
                if (r_iter == IDX_W'(ITER_N - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_DIFF1)
        else $error("accepted item did not start processing");
    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ITER |-> r_iter < IDX_W'(ITER_N))
        else $error("iteration counter out of range");
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_stat.out_free)
        else $error("finish issued while output register busy");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/plca_dp.sv
`default_nettype none
module plca_dp #(
    parameter int ANGLE_ITERS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  plca_pkg::t_ctl_cmd  i_cmd,
    output plca_pkg::t_ctl_stat o_stat,
    input  wire [1:0]           i_s_tuser,
    input  wire [15:0]          i_s_tdata,
    input  wire                 i_cfg_valid,
    input  wire                 i_cfg_index,
    input  wire [13:0]          i_cfg_data,
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output logic [0:0]          o_m_tuser,
    output logic [31:0]         o_m_tdata
);
    import plca_pkg::*;

    // truncate toward zero on arithmetic right shift
    function automatic logic signed [CORDIC_W-1:0] shr_tz(
        input logic signed [CORDIC_W-1:0] v, input logic [IDX_W-1:0] s);
        logic signed [CORDIC_W-1:0] m;
        m = -v;
        if (v[CORDIC_W-1]) begin
            return -(m >>> s);
        end
        return v >>> s;
    endfunction

    // configuration
    logic [13:0] r_tol;
    logic [7:0]  r_maxp;

    // polyline state
    logic [7:0]        r_vcnt, n_vcnt;
    logic [X_BITS-1:0] r_fx, r_bx, r_lx, n_fx;
    logic [Y_BITS-1:0] r_fy, r_by, r_ly, n_fy;
    logic              r_active, n_active;
    logic [1:0]        r_kind, n_kind;
    logic [6:0]        r_hlen, n_hlen;
    logic              r_hvalid, n_hvalid;
    logic              n_append;

    // item and work registers
    logic [1:0]               r_cmd;
    logic [X_BITS-1:0]        r_px, r_ex;
    logic [Y_BITS-1:0]        r_py, r_ey;
    logic signed [DX_W-1:0]   r_dfx, r_ux, r_vx;
    logic signed [DY_W-1:0]   r_dfy, r_uy, r_vy;
    logic                     r_snap;
    logic [D2_W-1:0]          r_d2seg;
    logic signed [PROD_W-1:0] r_dot, r_cross;
    logic signed [CORDIC_W-1:0] r_cx, r_cy;
    logic signed [Z_W-1:0]    r_cz;
    logic [15:0]              r_sv, r_sr;

    // output register
    logic        r_m_valid;
    logic        r_m_pair;
    logic [27:0] r_m_data;

    assign o_stat.out_free = !r_m_valid || i_m_tready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_pair;
    assign o_m_tdata  = {4'b0, r_m_data};

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol  <= TOL_RESET;
            r_maxp <= MAXP_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_TOL) r_tol <= i_cfg_data;
            else r_maxp <= i_cfg_data[7:0];
        end
    end

    // squared distance to first vertex
    logic [X_BITS-1:0] mag_fx;
    logic [Y_BITS-1:0] mag_fy;
    logic [D2_W-1:0]   d2_first;
    always_comb begin
        mag_fx   = r_dfx[DX_W-1] ? X_BITS'(-r_dfx) : X_BITS'(r_dfx);
        mag_fy   = r_dfy[DY_W-1] ? Y_BITS'(-r_dfy) : Y_BITS'(r_dfy);
        d2_first = D2_W'(mag_fx) * D2_W'(mag_fx) + D2_W'(mag_fy) * D2_W'(mag_fy);
    end

    // products of segment vectors
    logic signed [PROD_W-1:0] p_uxvx, p_uyvy, p_uxvy, p_uyvx, p_vxvx, p_vyvy;
    always_comb begin
        p_uxvx = PROD_W'(r_ux) * PROD_W'(r_vx);
        p_uyvy = PROD_W'(r_uy) * PROD_W'(r_vy);
        p_uxvy = PROD_W'(r_ux) * PROD_W'(r_vy);
        p_uyvx = PROD_W'(r_uy) * PROD_W'(r_vx);
        p_vxvx = PROD_W'(r_vx) * PROD_W'(r_vx);
        p_vyvy = PROD_W'(r_vy) * PROD_W'(r_vy);
    end

    // one CORDIC and one square-root step
    logic signed [CORDIC_W-1:0] xs, ys;
    logic [15:0]                sbit;
    logic [16:0]                trial;
    always_comb begin
        xs    = shr_tz(r_cx, i_cmd.idx);
        ys    = shr_tz(r_cy, i_cmd.idx);
        sbit  = 16'h4000 >> {i_cmd.idx[2:0], 1'b0};
        trial = {1'b0, r_sr} + {1'b0, sbit};
    end

    // final angle with exact-axis cases
    logic signed [Z_W-1:0] zf;
    logic [Z_W-1:0]        zr;
    logic [8:0]            ang;
    always_comb begin
        zf  = r_cz[Z_W-1] ? r_cz + ANG_360 : r_cz;
        zr  = Z_W'(zf + ANG_HALF);
        ang = zr[ANG_FRAC+8:ANG_FRAC];
        if (r_dot == 0 && r_cross == 0) ang = 9'd0;
        else if (r_cross == 0) ang = r_dot[PROD_W-1] ? 9'd180 : 9'd0;
        else if (r_dot == 0) ang = r_cross[PROD_W-1] ? 9'd270 : 9'd90;
    end

    // polyline update
    logic       e_pair;
    logic [6:0] e_len;
    logic [6:0] seg_len;
    always_comb begin
        n_vcnt   = r_vcnt;
        n_fx     = r_fx;
        n_fy     = r_fy;
        n_active = r_active;
        n_kind   = r_kind;
        n_hlen   = r_hlen;
        n_hvalid = r_hvalid;
        n_append = 1'b0;
        e_pair   = 1'b0;
        e_len    = 7'd0;
        seg_len  = r_sr[6:0];
        case (r_cmd)
            CMD_ERASE: begin
                n_vcnt = 8'd0;
                n_kind = KIND_NONE;
            end
            CMD_RESTORE: n_active = 1'b0;
            CMD_ADD: begin
                n_active = 1'b1;
                if (r_vcnt >= r_maxp) begin
                    n_active = 1'b0;
                end else if (r_vcnt != 0 && r_px == r_lx && r_py == r_ly) begin
                    n_active = 1'b0;
                end else begin
                    n_append = 1'b1;
                    n_vcnt   = r_vcnt + 1'b1;
                    if (r_snap) begin
                        n_active = 1'b0;
                        n_kind   = KIND_CLOSED;
                    end
                    if (r_vcnt == 8'd0) begin
                        n_kind = KIND_POINT;
                        n_fx   = r_px;
                        n_fy   = r_py;
                    end else if (r_vcnt == 8'd1) begin
                        n_kind = KIND_OPEN;
                        if (!r_hvalid) begin
                            n_hlen   = seg_len;
                            n_hvalid = 1'b1;
                        end
                    end else begin
                        if (r_kind != KIND_CLOSED && !r_snap) n_kind = KIND_OPEN;
                        e_pair = 1'b1;
                        if (r_hvalid) begin
                            e_len  = r_hlen;
                            n_hlen = seg_len;
                        end else begin
                            e_len = seg_len;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_s_tuser;
            r_px  <= i_s_tdata[X_BITS-1:0];
            r_py  <= i_s_tdata[X_BITS+Y_BITS-1:X_BITS];
        end
        if (i_cmd.diff1) begin
            r_dfx <= $signed({1'b0, r_px}) - $signed({1'b0, r_fx});
            r_dfy <= $signed({1'b0, r_py}) - $signed({1'b0, r_fy});
        end
        if (i_cmd.close) begin
            r_snap <= (r_vcnt != 8'd0) && (d2_first < D2_W'(r_tol));
            if ((r_vcnt != 8'd0) && (d2_first < D2_W'(r_tol))) begin
                r_ex <= r_fx;
                r_ey <= r_fy;
            end else begin
                r_ex <= r_px;
                r_ey <= r_py;
            end
        end
        if (i_cmd.diff2) begin
            r_ux <= $signed({1'b0, r_lx}) - $signed({1'b0, r_bx});
            r_uy <= $signed({1'b0, r_ly}) - $signed({1'b0, r_by});
            r_vx <= $signed({1'b0, r_ex}) - $signed({1'b0, r_lx});
            r_vy <= $signed({1'b0, r_ey}) - $signed({1'b0, r_ly});
        end
        if (i_cmd.mul) begin
            r_dot   <= p_uxvx + p_uyvy;
            r_cross <= p_uxvy - p_uyvx;
            r_d2seg <= D2_W'(p_vxvx + p_vyvy);
        end
        if (i_cmd.init) begin
            // fold into the right half plane, then prescale
            if (r_dot[PROD_W-1]) begin
                r_cx <= CORDIC_W'(-r_dot) <<< PRESCALE_SH;
                r_cy <= CORDIC_W'(-r_cross) <<< PRESCALE_SH;
                r_cz <= ANG_180;
            end else begin
                r_cx <= CORDIC_W'(r_dot) <<< PRESCALE_SH;
                r_cy <= CORDIC_W'(r_cross) <<< PRESCALE_SH;
                r_cz <= '0;
            end
            r_sv <= r_d2seg;
            r_sr <= '0;
        end
        if (i_cmd.step) begin
            if (i_cmd.idx < IDX_W'(ANGLE_ITERS)) begin
                if (!r_cy[CORDIC_W-1]) begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + Z_W'(atan_deg(i_cmd.idx));
                end else begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - Z_W'(atan_deg(i_cmd.idx));
                end
            end
            if (i_cmd.idx < IDX_W'(SQRT_STEPS)) begin
                if ({1'b0, r_sv} >= trial) begin
                    r_sv <= r_sv - trial[15:0];
                    r_sr <= (r_sr >> 1) + sbit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
            end
        end
    end

    // polyline state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt    <= '0;
            r_fx      <= '0;
            r_fy      <= '0;
            r_bx      <= '0;
            r_by      <= '0;
            r_lx      <= '0;
            r_ly      <= '0;
            r_active  <= 1'b0;
            r_kind    <= KIND_NONE;
            r_hlen    <= '0;
            r_hvalid  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_vcnt   <= n_vcnt;
                r_fx     <= n_fx;
                r_fy     <= n_fy;
                r_active <= n_active;
                r_kind   <= n_kind;
                r_hlen   <= n_hlen;
                r_hvalid <= n_hvalid;
                if (n_append) begin
                    r_bx <= r_lx;
                    r_by <= r_ly;
                    r_lx <= r_ex;
                    r_ly <= r_ey;
                end
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_m_pair <= e_pair;
            r_m_data <= {n_vcnt >= 8'd2, n_kind, n_active, n_vcnt,
                         e_pair ? ang : 9'd0, e_len};
        end
    end

`ifndef SYNTHESIS
    a_pair_needs_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && r_m_pair |-> r_m_data[23:16] >= 8'd3)
        else $error("pair emitted with fewer than three vertices");
    a_none_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && r_m_data[26:25] == KIND_NONE |-> r_m_data[23:16] == 8'd0)
        else $error("shape kind none with stored vertices");
    a_snap_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && n_append && r_snap |=> !r_active)
        else $error("closing vertex left block active");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/polyline_capture_length_angle.sv
// Sequence: an accepted item passes through the states DIFF1, CLOSE, DIFF2, MUL,
// INIT, N ITER steps and FIN, where N = max(ANGLE_ITERS, 8) is the count of shared
// CORDIC / square-root steps; FIN waits until the output register is free.
// A new item is taken only after the previous result has been registered.
// Reset: synchronous active-low i_rst_n clears the polyline, the output
// register and the controller; configuration returns to tolerance 25, limit 101.
`default_nettype none
module polyline_capture_length_angle #(
    parameter int ANGLE_ITERS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input items
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // point_x[6:0], point_y[12:7], zero pad
    input  wire  [1:0]  i_s_tuser,   // cmd[1:0]
    // result items
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [31:0] o_m_tdata,   // seg_length[6:0], turn_angle[15:7],
                                     // point_count[23:16], active[24],
                                     // shape_kind[26:25], draft_ready[27], zero pad
    output logic [0:0]  o_m_tuser,   // pair_valid[0]
    // configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [13:0] i_cfg_data
);
    import plca_pkg::*;

    t_ctl_cmd  ctl_cmd;
    t_ctl_stat ctl_stat;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    plca_ctrl #(
        .ANGLE_ITERS(ANGLE_ITERS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (ctl_stat),
        .o_cmd      (ctl_cmd)
    );

    plca_dp #(
        .ANGLE_ITERS(ANGLE_ITERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctl_cmd),
        .o_stat      (ctl_stat),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tuser   (o_m_tuser),
        .o_m_tdata   (o_m_tdata)
    );

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import plca_pkg::*;

    localparam int LIMIT_CYCLES = 600000;

    // command code with no function
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic       pair_valid;
        logic [6:0] seg_length;
        logic [8:0] turn_angle;
        logic [7:0] point_count;
        logic       active;
        logic [1:0] shape_kind;
        logic       draft_ready;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [13:0] i_cfg_data = '0;

    polyline_capture_length_angle i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow of the polyline state
    int unsigned tol_sq, max_pts, n_vert;
    int unsigned fx, fy, blx, bly, lx, ly, held_len;
    bit          act, held_ok;
    logic [1:0]  shape;

    t_result     pending_q[$];
    int          errors = 0;
    int          sent = 0;
    int          received = 0;
    int          pairs = 0;
    longint      cycles = 0;
    bit          gaps_on = 1'b1;

    const int angle_table[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
        58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    function automatic int unsigned floor_sqrt(int unsigned v);
        int unsigned r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    function automatic int unsigned sq_dist(int ax, int ay, int bx, int by);
        return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    endfunction

    function automatic longint shift_tz(longint v, int s);
        return v >= 0 ? (v >>> s) : -((-v) >>> s);
    endfunction

    // atan2(y, x) in rounded degrees, same CORDIC as the block
    function automatic int unsigned heading_deg(longint x, longint y);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (y == 0) return x > 0 ? 0 : 180;
        if (x == 0) return y > 0 ? 90 : 270;
        if (x < 0) begin
            x = -x; y = -y; z = 180 * 65536;
        end
        x = x * 1048576;
        y = y * 1048576;
        for (int i = 0; i < 16; i++) begin
            xs = shift_tz(x, i);
            ys = shift_tz(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + angle_table[i];
            end else begin
                x = x - ys; y = y + xs; z = z - angle_table[i];
            end
        end
        if (z < 0) z = z + 360 * 65536;
        return int'((z + 32768) >>> 16);
    endfunction

    function automatic t_result predict_step(logic [1:0] cmd, int unsigned px,
                                             int unsigned py);
        t_result r;
        int unsigned len;
        longint ux, uy, vx, vy;
        r = '0;
        if (cmd == CMD_ERASE) begin
            n_vert = 0; shape = KIND_NONE;
        end else if (cmd == CMD_RESTORE) begin
            act = 1'b0;
        end else if (cmd == CMD_ADD) begin
            act = 1'b1;
            if (n_vert >= max_pts) begin
                act = 1'b0;
            end else if (n_vert > 0 && px == lx && py == ly) begin
                act = 1'b0;
            end else begin
                n_vert++;
                if (n_vert >= 2 && sq_dist(px, py, fx, fy) < tol_sq) begin
                    px = fx; py = fy; act = 1'b0; shape = KIND_CLOSED;
                end
                if (n_vert == 1) begin
                    shape = KIND_POINT; fx = px; fy = py;
                end else begin
                    len = floor_sqrt(sq_dist(lx, ly, px, py));
                    if (n_vert == 2) begin
                        shape = KIND_OPEN;
                        if (!held_ok) begin
                            held_len = len; held_ok = 1'b1;
                        end
                    end else begin
                        ux = longint'(lx) - blx; uy = longint'(ly) - bly;
                        vx = longint'(px) - lx;  vy = longint'(py) - ly;
                        r.turn_angle = 9'(heading_deg(ux * vx + uy * vy,
                                                      ux * vy - uy * vx));
                        if (shape != KIND_CLOSED) shape = KIND_OPEN;
                        r.pair_valid = 1'b1;
                        if (held_ok) begin
                            r.seg_length = 7'(held_len); held_len = len;
                        end else begin
                            r.seg_length = 7'(len);
                        end
                    end
                end
                blx = lx; bly = ly; lx = px; ly = py;
            end
        end
        r.point_count = 8'(n_vert);
        r.active = act;
        r.shape_kind = shape;
        r.draft_ready = n_vert >= 2;
        return r;
    endfunction

    // valid stays high into the next item unless an idle burst comes first
    task automatic send_item(logic [1:0] cmd, int unsigned px, int unsigned py);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {3'b0, 6'(py), 7'(px)};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_q.push_back(predict_step(cmd, px, py));
        sent++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, int unsigned val);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 14'(val);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_TOL) tol_sq = val & 16'h3FFF;
        else max_pts = val & 8'hFF;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result got, want;
        cycles <= cycles + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tuser[0], o_m_tdata[6:0], o_m_tdata[15:7], o_m_tdata[23:16],
                   o_m_tdata[24], o_m_tdata[26:25], o_m_tdata[27]};
            received++;
            if (got.pair_valid) pairs++;
            if (pending_q.size() == 0) begin
                $error("result with nothing expected: %h", o_m_tdata);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (got.pair_valid !== want.pair_valid) begin
                    $error("pair_valid exp %0d got %0d", want.pair_valid, got.pair_valid);
                    errors++;
                end
                if (got.seg_length !== want.seg_length) begin
                    $error("seg_length exp %0d got %0d", want.seg_length, got.seg_length);
                    errors++;
                end
                if (got.turn_angle !== want.turn_angle) begin
                    $error("turn_angle exp %0d got %0d", want.turn_angle, got.turn_angle);
                    errors++;
                end
                if (got.point_count !== want.point_count) begin
                    $error("point_count exp %0d got %0d", want.point_count,
                           got.point_count);
                    errors++;
                end
                if (got.active !== want.active) begin
                    $error("active exp %0d got %0d", want.active, got.active);
                    errors++;
                end
                if (got.shape_kind !== want.shape_kind) begin
                    $error("shape_kind exp %0d got %0d", want.shape_kind, got.shape_kind);
                    errors++;
                end
                if (got.draft_ready !== want.draft_ready) begin
                    $error("draft_ready exp %0d got %0d", want.draft_ready,
                           got.draft_ready);
                    errors++;
                end
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (gaps_on && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    // edge cases: extremes, every command, closing, repeats
    task automatic test_directed();
        send_item(CMD_ADD, 0, 0);
        send_item(CMD_ADD, 0, 0);          // repeat of last vertex
        send_item(CMD_ADD, 1, 1);          // second vertex closes onto first
        send_item(CMD_ADD, 99, 0);         // add after close
        send_item(CMD_ADD, 99, 63);        // 90 degree turn
        send_item(CMD_ADD, 0, 63);
        send_item(CMD_ADD, 99, 63);        // reversal
        send_item(CMD_ADD, 2, 1);          // closes
        send_item(CMD_UNUSED, 127, 63);
        send_item(CMD_RESTORE, 5, 5);
        send_item(CMD_ERASE, 0, 0);
        send_item(CMD_ADD, 10, 10);
        send_item(CMD_ADD, 50, 30);        // keeps older held length
        send_item(CMD_ADD, 70, 20);
        send_item(CMD_ADD, 127, 0);        // full-width x bits
        send_item(CMD_ERASE, 0, 0);
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_MAXP, 1);
        write_reg(CFG_TOL, 0);
        send_item(CMD_ADD, 3, 3);
        send_item(CMD_ADD, 4, 4);          // limit reached
        send_item(CMD_ERASE, 0, 0);
        write_reg(CFG_MAXP, 255);
        write_reg(CFG_TOL, 16383);
        send_item(CMD_ADD, 0, 0);
        send_item(CMD_ADD, 99, 63);        // everything closes
        send_item(CMD_ERASE, 0, 0);
        write_reg(CFG_MAXP, 0);
        send_item(CMD_ADD, 7, 7);          // refused
        send_item(CMD_ERASE, 0, 0);
    endtask

    // random polylines with occasional noise
    task automatic test_random(int n, bit stall);
        int unsigned tol_opts[4] = '{0, 25, 200, 16383};
        int unsigned max_opts[4] = '{3, 20, 101, 255};
        int done;
        done = 0;
        gaps_on = stall;
        while (done < n) begin
            int len;
            write_reg(CFG_TOL, tol_opts[$urandom_range(0, 3)] == 0 ? 0 :
                      ($urandom_range(0, 1) ? tol_opts[$urandom_range(0, 3)]
                                            : $urandom_range(0, 16383)));
            write_reg(CFG_MAXP, max_opts[$urandom_range(0, 3)]);
            send_item(CMD_ERASE, $urandom_range(0, 127), $urandom_range(0, 63));
            len = $urandom_range(3, 40);
            for (int k = 0; k < len; k++) begin
                int r;
                r = $urandom_range(0, 19);
                if (r == 0) send_item(CMD_RESTORE, $urandom_range(0, 127),
                                      $urandom_range(0, 63));
                else if (r == 1) send_item(CMD_UNUSED, $urandom_range(0, 127),
                                           $urandom_range(0, 63));
                else if (r == 2) send_item(CMD_ADD, lx, ly);
                else if (r == 3) send_item(CMD_ERASE, 0, 0);
                else if (r == 4) send_item(CMD_ADD, $urandom_range(0, 127),
                                           $urandom_range(0, 63));
                else send_item(CMD_ADD, $urandom_range(0, 99), $urandom_range(0, 63));
                done++;
            end
        end
    endtask

    initial begin
        tol_sq = TOL_RESET; max_pts = MAXP_RESET;
        n_vert = 0; fx = 0; fy = 0; blx = 0; bly = 0; lx = 0; ly = 0;
        act = 0; shape = KIND_NONE; held_len = 0; held_ok = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_random(1500, 1'b1);
        test_random(300, 1'b0);
        wait_drained();
        $display("Sent %0d items, checked %0d results, %0d length/angle pairs,",
                 sent, received, pairs);
        $display("under tolerance and vertex-limit settings including both extremes.");
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycles > LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/plca_pkg.sv
rtl/core/plca_ctrl.sv
rtl/core/plca_dp.sv
rtl/core/polyline_capture_length_angle.sv
verif/testbench.sv
